FILE: rtl/core/tbcf_pkg.sv
// Package for the two-band crossover filter: widths, codes, control struct
// and the saturation helpers used by the datapath.
// No dependencies.
package tbcf_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 20;
    localparam int GUARD_W   = 8;
    localparam int STATE_W   = SAMPLE_W + 16;
    localparam int HALF_W    = STATE_W / 2;
    localparam int MB_W      = (SAMPLE_W > HALF_W + 1) ? SAMPLE_W : HALF_W + 1;
    localparam int PROD_W    = COEF_W + MB_W;
    localparam int P_SHIFT   = COEF_FRAC - GUARD_W;
    localparam int PS_W      = ((PROD_W > STATE_W + P_SHIFT) ? PROD_W : STATE_W + P_SHIFT) + 1;
    localparam int T_W       = PS_W - P_SHIFT;
    localparam int ACC_W     = COEF_W + STATE_W;
    localparam int Q_W       = ACC_W - COEF_FRAC;
    localparam int DIFF_W    = T_W + 1;
    localparam int YR_W      = STATE_W + 1;
    localparam int R_W       = YR_W - GUARD_W;
    localparam int SR_W      = R_W + 1;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = $clog2(NUM_REGS);

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_FF0,
        REG_LOW_FF1,
        REG_LOW_FF2,
        REG_HIGH_FF0,
        REG_HIGH_FF1,
        REG_HIGH_FF2,
        REG_FB1,
        REG_FB2
    } reg_idx_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [3:0] {
        STEP_MUL_FF0,
        STEP_Y,
        STEP_T1,
        STEP_T2,
        STEP_ACC_Q1,
        STEP_Q1,
        STEP_D1,
        STEP_Q2,
        STEP_D2
    } step_t;

    typedef enum logic [2:0] {
        CSEL_FF0,
        CSEL_FF1,
        CSEL_FF2,
        CSEL_FB1,
        CSEL_FB2
    } coef_sel_t;

    typedef struct packed {
        logic  busy;
        logic  high;
        step_t step;
        logic  finish;
    } ctl_t;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return STATE_W'(hi);
        end else if (v < lo) begin
            return STATE_W'(lo);
        end
        return STATE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SR_W-1:0] v);
        logic signed [SR_W-1:0] hi;
        logic signed [SR_W-1:0] lo;
        hi = {{(SR_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return SAMPLE_W'(hi);
        end else if (v < lo) begin
            return SAMPLE_W'(lo);
        end
        return SAMPLE_W'(v);
    endfunction

endpackage

FILE: rtl/core/two_band_crossover_filter.sv
// Two-band crossover: a low-pass and a high-pass biquad in transposed direct
// form II sharing their feedback coefficients, with one time-shared
// multiplier. Each band runs nine multiplier/accumulate steps, set by the
// seven products per band through the single multiplier; the block is
// ready again after both bands. The result waits in an output register, so
// the block takes the next item while it is unread; it holds its last step
// only if a second result would overwrite an unread one. Coefficients are
// to be written only while idle; the block itself does not enforce this.
// Depends on tbcf_pkg, tbcf_coef_regs, tbcf_mul and tbcf_ctrl.
module two_band_crossover_filter
    import tbcf_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_low_band,
    output logic signed [SAMPLE_W-1:0] m_high_band
);

    localparam logic signed [PS_W-1:0] P_HALF =
        {{(PS_W-P_SHIFT){1'b0}}, 1'b1, {(P_SHIFT-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Q_HALF =
        {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [YR_W-1:0] G_HALF =
        {{(YR_W-GUARD_W){1'b0}}, 1'b1, {(GUARD_W-1){1'b0}}};

    ctl_t                       ctl;
    logic                       out_free;
    coef_sel_t                  coef_sel;
    logic signed [COEF_W-1:0]   coef;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [STATE_W-1:0]  y_reg;
    logic signed [T_W-1:0]      t1_reg, t2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [STATE_W-1:0]  q_reg;
    logic signed [STATE_W-1:0]  low_d1_reg, low_d2_reg, high_d1_reg, high_d2_reg;
    logic signed [SAMPLE_W-1:0] lo_pend_reg;
    logic signed [SAMPLE_W-1:0] m_low_band_reg, m_high_band_reg;
    logic                       m_valid_reg;

    logic signed [STATE_W-1:0]  d1_cur, d2_cur, d_sel;
    logic signed [PS_W-1:0]     p_sum;
    logic signed [T_W-1:0]      p_round;
    logic signed [ACC_W-1:0]    acc_load, q_sum;
    logic signed [Q_W-1:0]      q_shift;
    logic signed [STATE_W-1:0]  q_next;
    logic signed [T_W-1:0]      t_sel;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [STATE_W-1:0]  d_new;
    logic signed [YR_W-1:0]     yr_sum;
    logic signed [R_W-1:0]      yr;
    logic signed [SAMPLE_W-1:0] lo_sat, hi_sat;

    assign out_free = !m_valid_reg || m_ready;

    tbcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    tbcf_coef_regs u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .high      (ctl.high),
        .sel       (coef_sel),
        .coef      (coef)
    );

    tbcf_mul u_mul (
        .aclk (aclk),
        .a    (coef),
        .b    (mul_b),
        .prod (prod)
    );

    // Operand select: feed-forward products on the sample, feedback products
    // on the two halves of y (low half unsigned, high half signed).
    always_comb begin
        case (ctl.step)
            STEP_MUL_FF0: begin
                coef_sel = CSEL_FF0;
                mul_b    = MB_W'(sample_reg);
            end
            STEP_Y: begin
                coef_sel = CSEL_FF1;
                mul_b    = MB_W'(sample_reg);
            end
            STEP_T1: begin
                coef_sel = CSEL_FF2;
                mul_b    = MB_W'(sample_reg);
            end
            STEP_T2: begin
                coef_sel = CSEL_FB1;
                mul_b    = MB_W'({1'b0, y_reg[HALF_W-1:0]});
            end
            STEP_ACC_Q1: begin
                coef_sel = CSEL_FB1;
                mul_b    = MB_W'(signed'(y_reg[STATE_W-1:HALF_W]));
            end
            STEP_Q1: begin
                coef_sel = CSEL_FB2;
                mul_b    = MB_W'({1'b0, y_reg[HALF_W-1:0]});
            end
            STEP_D1: begin
                coef_sel = CSEL_FB2;
                mul_b    = MB_W'(signed'(y_reg[STATE_W-1:HALF_W]));
            end
            default: begin
                coef_sel = CSEL_FF0;
                mul_b    = '0;
            end
        endcase
    end

    assign d1_cur = ctl.high ? high_d1_reg : low_d1_reg;
    assign d2_cur = ctl.high ? high_d2_reg : low_d2_reg;

    always_comb begin
        case (ctl.step)
            STEP_Y:  d_sel = d1_cur;
            STEP_T1: d_sel = d2_cur;
            default: d_sel = '0;
        endcase
    end

    // Fold the delay word in before the rounding shift: the floor is exact.
    assign p_sum   = PS_W'(prod) + P_HALF + (PS_W'(d_sel) <<< P_SHIFT);
    assign p_round = T_W'(p_sum >>> P_SHIFT);

    assign acc_load = ACC_W'(prod) + Q_HALF;
    assign q_sum    = acc_reg + (ACC_W'(prod) <<< HALF_W);
    assign q_shift  = Q_W'(q_sum >>> COEF_FRAC);
    assign q_next   = sat_state(ACC_W'(q_shift));

    assign t_sel = (ctl.step == STEP_D1) ? t1_reg : t2_reg;
    assign diff  = DIFF_W'(t_sel) - DIFF_W'(q_reg);
    assign d_new = sat_state(ACC_W'(diff));

    assign yr_sum = YR_W'(y_reg) + G_HALF;
    assign yr     = R_W'(yr_sum >>> GUARD_W);
    assign lo_sat = sat_sample(SR_W'(yr));
    assign hi_sat = sat_sample(-SR_W'(yr));

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
        end
        if (ctl.busy) begin
            case (ctl.step)
                STEP_Y:      y_reg   <= sat_state(ACC_W'(p_round));
                STEP_T1:     t1_reg  <= p_round;
                STEP_T2:     t2_reg  <= p_round;
                STEP_ACC_Q1: acc_reg <= acc_load;
                STEP_Q1:     q_reg   <= q_next;
                STEP_D1:     acc_reg <= acc_load;
                STEP_Q2:     q_reg   <= q_next;
                STEP_D2: begin
                    if (!ctl.high) begin
                        lo_pend_reg <= lo_sat;
                    end
                end
                default: ;
            endcase
        end
        if (ctl.finish) begin
            m_low_band_reg  <= lo_pend_reg;
            m_high_band_reg <= hi_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_d1_reg  <= '0;
            low_d2_reg  <= '0;
            high_d1_reg <= '0;
            high_d2_reg <= '0;
        end else if (ctl.busy) begin
            case (ctl.step)
                STEP_D1: begin
                    if (ctl.high) begin
                        high_d1_reg <= d_new;
                    end else begin
                        low_d1_reg <= d_new;
                    end
                end
                STEP_D2: begin
                    if (ctl.high) begin
                        high_d2_reg <= d_new;
                    end else begin
                        low_d2_reg <= d_new;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_low_band  = m_low_band_reg;
    assign m_high_band = m_high_band_reg;

endmodule

FILE: rtl/core/tbcf_coef_regs.sv
// Coefficient register file for the crossover filter; selects the
// coefficient the shared multiplier needs for the current section.
// Depends on tbcf_pkg.
module tbcf_coef_regs
    import tbcf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,
    input  logic                     high,
    input  coef_sel_t                sel,
    output logic signed [COEF_W-1:0] coef
);

    logic signed [COEF_W-1:0] low_ff0_reg, low_ff1_reg, low_ff2_reg;
    logic signed [COEF_W-1:0] high_ff0_reg, high_ff1_reg, high_ff2_reg;
    logic signed [COEF_W-1:0] fb1_reg, fb2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_ff0_reg  <= '0;
            low_ff1_reg  <= '0;
            low_ff2_reg  <= '0;
            high_ff0_reg <= '0;
            high_ff1_reg <= '0;
            high_ff2_reg <= '0;
            fb1_reg      <= '0;
            fb2_reg      <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_LOW_FF0:  low_ff0_reg  <= cfg_data;
                REG_LOW_FF1:  low_ff1_reg  <= cfg_data;
                REG_LOW_FF2:  low_ff2_reg  <= cfg_data;
                REG_HIGH_FF0: high_ff0_reg <= cfg_data;
                REG_HIGH_FF1: high_ff1_reg <= cfg_data;
                REG_HIGH_FF2: high_ff2_reg <= cfg_data;
                REG_FB1:      fb1_reg      <= cfg_data;
                REG_FB2:      fb2_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            CSEL_FF0: coef = high ? high_ff0_reg : low_ff0_reg;
            CSEL_FF1: coef = high ? high_ff1_reg : low_ff1_reg;
            CSEL_FF2: coef = high ? high_ff2_reg : low_ff2_reg;
            CSEL_FB1: coef = fb1_reg;
            CSEL_FB2: coef = fb2_reg;
            default:  coef = '0;
        endcase
    end

endmodule

FILE: rtl/core/tbcf_mul.sv
// Shared signed multiplier of the crossover filter with a registered product.
// Depends on tbcf_pkg.
module tbcf_mul
    import tbcf_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [COEF_W-1:0] a,
    input  logic signed [MB_W-1:0]   b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/tbcf_ctrl.sv
// Sequencer of the crossover filter: walks the nine steps of each section,
// low band first; holds the high band's last step while the slot is full.
// Depends on tbcf_pkg.
module tbcf_ctrl
    import tbcf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic out_free,
    output logic s_ready,
    output ctl_t ctl
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   high_reg, high_next;

    function automatic step_t succ(input step_t s);
        case (s)
            STEP_MUL_FF0: return STEP_Y;
            STEP_Y:       return STEP_T1;
            STEP_T1:      return STEP_T2;
            STEP_T2:      return STEP_ACC_Q1;
            STEP_ACC_Q1:  return STEP_Q1;
            STEP_Q1:      return STEP_D1;
            STEP_D1:      return STEP_Q2;
            STEP_Q2:      return STEP_D2;
            default:      return STEP_MUL_FF0;
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_MUL_FF0;
            high_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            high_reg  <= high_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        high_next  = high_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                    step_next  = STEP_MUL_FF0;
                    high_next  = 1'b0;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_D2) begin
                    if (!high_reg) begin
                        high_next = 1'b1;
                        step_next = STEP_MUL_FF0;
                    end else if (out_free) begin
                        state_next = ST_IDLE;
                        step_next  = STEP_MUL_FF0;
                        high_next  = 1'b0;
                    end
                end else begin
                    step_next = succ(step_reg);
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = STEP_MUL_FF0;
                high_next  = 1'b0;
            end
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        ctl.busy   = (state_reg == ST_RUN);
        ctl.high   = high_reg;
        ctl.step   = step_reg;
        ctl.finish = (state_reg == ST_RUN) && (step_reg == STEP_D2) && high_reg && out_free;
    end

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == STEP_MUL_FF0 && !high_reg))
        else $error("sequencer did not start at the first step of the low band");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg == STEP_D2 && high_reg && !out_free)
        |=> (state_reg == ST_RUN && step_reg == STEP_D2 && high_reg))
        else $error("final step left while the result slot was full");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish |=> s_ready)
        else $error("block not ready after finishing an item");

    a_band_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(high_reg) |-> ($past(step_reg) == STEP_D2))
        else $error("high band started before the low band finished");

endmodule
